### sv/tmw_pkg.sv
// shared constants, codes and control types of the time map warp block
package tmw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 16;

  localparam int OP_W      = 3;
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 48;
  localparam int LEN_W     = 32;
  localparam int DEN_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam int PT_W   = FRAC_BITS + 1;
  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int NUM_W  = LEN_W + 8;
  localparam int DIV_W  = TIME_W + FRAC_BITS;
  localparam int PROD_W = DIV_W + PT_W;

  // remainder after the integer part of t / span has been resolved
  localparam int DIV_SPLIT = TIME_W;

  localparam logic [PT_W-1:0]   ONE_Q      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [7:0]        BEAT_SCALE = 8'd240;
  localparam logic [TIME_W-1:0] TIME_MAX   = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [DEN_W-1:0]  DEN_RESET  = 8'd4;

  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_TO_CLOCK = 3'd2;
  localparam logic [OP_W-1:0] OP_TO_REAL  = 3'd3;
  localparam logic [OP_W-1:0] OP_WARP     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_DEN   = 2'd1;

  typedef enum logic [1:0] {
    DIV_SPAN,
    DIV_TIME,
    DIV_SEG
  } div_sel_t;

  typedef enum logic {
    MUL_SEG,
    MUL_WARP
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     insert;
    logic     span_prep;
    logic     div_start;
    div_sel_t div_sel;
    logic     walk_init;
    logic     walk_step;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     seg_take;
    logic     map_take;
    logic     pass_take;
    logic     warp_take;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            walk_last;
    logic            seg_skip;
    logic            warp_pass;
    logic            span_zero;
    logic            div_done;
    logic            mul_done;
  } stat_t;

  function automatic logic [PT_W-1:0] clamp_unit(input logic signed [DATA_W-1:0] s);
    logic signed [DATA_W-1:0] one_s;
    logic [PT_W-1:0]          res;
    one_s = $signed(DATA_W'(ONE_Q));
    if (s < 0) begin
      res = '0;
    end else if (s > one_s) begin
      res = ONE_Q;
    end else begin
      res = s[PT_W-1:0];
    end
    return res;
  endfunction

endpackage

### sv/time_map_warp.sv
// Piecewise-linear time map with up to 16 sorted breakpoints and clock-time warp, Q16.16.
// One item at a time: a phase map walks one breakpoint per cycle, then runs at most a
// serial multiply and a serial divide; a warp makes at most three passes through the
// shared one-bit-per-cycle divider plus two serial multiplies. A finished result waits
// in the output register while the next item is taken in. Configuration writes are
// taken every cycle and must only happen while the block is idle.
module time_map_warp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tmw_pkg::OP_W-1:0]          in_op,
  input  logic signed [tmw_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [tmw_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [tmw_pkg::DATA_W-1:0] in_phase,
  input  logic [tmw_pkg::DATA_W-1:0]        in_tempo,
  input  logic signed [tmw_pkg::TIME_W-1:0] in_clock_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tmw_pkg::TIME_W-1:0] out_result_value,
  output logic                              out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tmw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmw_pkg::LEN_W-1:0]         cfg_data
);

  tmw_pkg::cmd_t  cmd;
  tmw_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_phase         (in_phase),
    .in_tempo         (in_tempo),
    .in_clock_time    (in_clock_time),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

`ifndef ASSERT_OFF
  // one item in flight: no second transfer right after an accepted one
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a new result is only written into a free or draining output slot
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result overwrote a pending output");

  // the divider never reports completion directly after it is started
  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !stat.div_done)
    else $error("divider finished one cycle after start");
`endif

endmodule

### sv/tmw_div.sv
// restoring divider, one quotient bit per cycle, with a remainder tap after the first DIV_SPLIT quotient bits
module tmw_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tmw_pkg::DIV_W-1:0]  dividend,
  input  logic [tmw_pkg::DIV_W-1:0]  divisor,
  output logic                       done,
  output logic [tmw_pkg::DIV_W-1:0]  quot,
  output logic [tmw_pkg::DIV_W-1:0]  rem_mid
);

  localparam int DC_W = $clog2(tmw_pkg::DIV_W);

  logic                      busy_r;
  logic                      done_r;
  logic [DC_W-1:0]           cnt_r;
  logic [tmw_pkg::DIV_W-1:0] q_r;
  logic [tmw_pkg::DIV_W-1:0] r_r;
  logic [tmw_pkg::DIV_W-1:0] d_r;
  logic [tmw_pkg::DIV_W-1:0] mid_r;
  logic [tmw_pkg::DIV_W:0]   trial;
  logic                      fits;
  logic [tmw_pkg::DIV_W-1:0] r_nxt;

  assign trial = {r_r, q_r[tmw_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_comb begin
    if (fits) begin
      r_nxt = tmw_pkg::DIV_W'(trial - {1'b0, d_r});
    end else begin
      r_nxt = trial[tmw_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DC_W'(tmw_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      d_r <= divisor;
      r_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[tmw_pkg::DIV_W-2:0], fits};
      r_r <= r_nxt;
      if (cnt_r == DC_W'(tmw_pkg::DIV_SPLIT - 1)) begin
        mid_r <= r_nxt;
      end
    end
  end

  assign done    = done_r;
  assign quot    = q_r;
  assign rem_mid = mid_r;

endmodule

### sv/tmw_mul.sv
// shift-and-add multiplier, one multiplier bit per cycle
module tmw_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tmw_pkg::DIV_W-1:0]  a,
  input  logic [tmw_pkg::PT_W-1:0]   b,
  output logic                       done,
  output logic [tmw_pkg::PROD_W-1:0] prod
);

  localparam int MC_W = $clog2(tmw_pkg::PT_W + 1);

  logic                       busy_r;
  logic                       done_r;
  logic [MC_W-1:0]            cnt_r;
  logic [tmw_pkg::PROD_W-1:0] ash_r;
  logic [tmw_pkg::PT_W-1:0]   b_r;
  logic [tmw_pkg::PROD_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MC_W'(tmw_pkg::PT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ash_r <= tmw_pkg::PROD_W'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      ash_r <= {ash_r[tmw_pkg::PROD_W-2:0], 1'b0};
      b_r   <= b_r >> 1;
      if (b_r[0]) begin
        acc_r <= acc_r + ash_r;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### sv/tmw_dp.sv
// datapath: breakpoint table, polyline walk, span and warp arithmetic, result register
module tmw_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tmw_pkg::cmd_t                     cmd,
  output tmw_pkg::stat_t                    stat,
  input  logic [tmw_pkg::OP_W-1:0]          in_op,
  input  logic signed [tmw_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [tmw_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [tmw_pkg::DATA_W-1:0] in_phase,
  input  logic [tmw_pkg::DATA_W-1:0]        in_tempo,
  input  logic signed [tmw_pkg::TIME_W-1:0] in_clock_time,
  input  logic                              cfg_we,
  input  logic [tmw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmw_pkg::LEN_W-1:0]         cfg_data,
  output logic signed [tmw_pkg::TIME_W-1:0] out_result_value,
  output logic                              out_status
);

  localparam int PT_W  = tmw_pkg::PT_W;
  localparam int DIV_W = tmw_pkg::DIV_W;
  localparam int CNT_W = tmw_pkg::CNT_W;
  localparam int NUM_W = tmw_pkg::NUM_W;

  // breakpoint table
  logic [PT_W-1:0] tx_r [tmw_pkg::MAX_POINTS];
  logic [PT_W-1:0] ty_r [tmw_pkg::MAX_POINTS];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] skew_r;

  // configuration
  logic [tmw_pkg::LEN_W-1:0] map_len_r;
  logic [tmw_pkg::DEN_W-1:0] beat_den_r;

  // captured item
  logic [tmw_pkg::OP_W-1:0]   op_r;
  logic [PT_W-1:0]            cx_r;
  logic [PT_W-1:0]            cy_r;
  logic                       skew_in_r;
  logic [tmw_pkg::DATA_W-1:0] tempo_r;
  logic [tmw_pkg::TIME_W-1:0] t_r;
  logic                       by_y_r;
  logic [PT_W-1:0]            v_r;

  // walk and segment
  logic [CNT_W-1:0] i_r;
  logic [PT_W-1:0]  my_r;
  logic [PT_W-1:0]  ax_r;
  logic [PT_W-1:0]  ay_r;
  logic [PT_W-1:0]  bx_r;
  logic [PT_W-1:0]  by_r;
  logic [PT_W-1:0]  mapped_r;

  // warp
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  den_r;
  logic [DIV_W-1:0]  span_r;
  logic [DIV_W-1:0]  base_r;
  tmw_pkg::div_sel_t dsel_r;

  // result
  logic [tmw_pkg::TIME_W-1:0] result_r;
  logic                       status_r;
  logic [tmw_pkg::TIME_W-1:0] out_val_r;
  logic                       out_st_r;

  logic                       full;
  logic                       ins_en;
  logic [tmw_pkg::MAX_POINTS-1:0] gt;

  logic [tmw_pkg::IDX_W-1:0] rd_idx;
  logic                      at_end;
  logic [PT_W-1:0]           rd_x;
  logic [PT_W-1:0]           ny;
  logic [PT_W-1:0]           key;
  logic                      adv;

  logic [PT_W-1:0] ra, rb, wa, wb, wdiff, rdiff, vdiff;
  logic            up;
  logic            seg_skip;

  logic                       div_start;
  logic [DIV_W-1:0]           div_a;
  logic [DIV_W-1:0]           div_b;
  logic                       div_done;
  logic [DIV_W-1:0]           quot;
  logic [DIV_W-1:0]           rem_mid;
  logic [DIV_W-1:0]           mul_a;
  logic [PT_W-1:0]            mul_b;
  logic                       mul_done;
  logic [tmw_pkg::PROD_W-1:0] prod;
  logic [DIV_W:0]             warp_sum;
  logic [PT_W-1:0]            seg_val;

  assign full   = (cnt_r == CNT_W'(tmw_pkg::MAX_POINTS));
  assign ins_en = cmd.insert && !full;

  always_comb begin
    for (int k = 0; k < tmw_pkg::MAX_POINTS; k++) begin
      gt[k] = (CNT_W'(k) < cnt_r) && (tx_r[k] > cx_r);
    end
  end

  // stable sorted insert: entries above x shift up by one
  for (genvar k = 0; k < tmw_pkg::MAX_POINTS; k++) begin : g_ent
    logic            prev_gt;
    logic            place;
    logic [PT_W-1:0] below_x;
    logic [PT_W-1:0] below_y;
    if (k == 0) begin : g_first
      assign prev_gt = 1'b0;
      assign below_x = '0;
      assign below_y = '0;
    end else begin : g_rest
      assign prev_gt = gt[k-1];
      assign below_x = tx_r[k-1];
      assign below_y = ty_r[k-1];
    end
    assign place = (CNT_W'(k) <= cnt_r) && !prev_gt && (gt[k] || (CNT_W'(k) == cnt_r));

    always_ff @(posedge clk) begin
      if (ins_en) begin
        if (prev_gt) begin
          tx_r[k] <= below_x;
          ty_r[k] <= below_y;
        end else if (place) begin
          tx_r[k] <= cx_r;
          ty_r[k] <= cy_r;
        end
      end
    end
  end

  // one vertex of the polyline per cycle, y as running maximum
  assign rd_idx = i_r[tmw_pkg::IDX_W-1:0];
  assign at_end = (i_r == cnt_r);
  assign rd_x   = tx_r[rd_idx];
  assign ny     = (ty_r[rd_idx] > my_r) ? ty_r[rd_idx] : my_r;
  assign key    = by_y_r ? ny : rd_x;
  assign adv    = !at_end && (v_r > key);

  assign ra       = by_y_r ? ay_r : ax_r;
  assign rb       = by_y_r ? by_r : bx_r;
  assign wa       = by_y_r ? ax_r : ay_r;
  assign wb       = by_y_r ? bx_r : by_r;
  assign up       = (wb >= wa);
  assign wdiff    = up ? (wb - wa) : (wa - wb);
  assign rdiff    = rb - ra;
  assign vdiff    = v_r - ra;
  assign seg_skip = (rb <= ra) || (v_r < ra);

  always_comb begin
    if (seg_skip) begin
      seg_val = wa;
    end else if (up) begin
      seg_val = wa + quot[PT_W-1:0];
    end else begin
      seg_val = wa - quot[PT_W-1:0];
    end
  end

  always_comb begin
    case (cmd.div_sel)
      tmw_pkg::DIV_SPAN: begin
        div_a = DIV_W'({num_r, {tmw_pkg::FRAC_BITS{1'b0}}});
        div_b = DIV_W'(den_r);
      end
      tmw_pkg::DIV_TIME: begin
        div_a = {t_r, {tmw_pkg::FRAC_BITS{1'b0}}};
        div_b = span_r;
      end
      default: begin
        div_a = DIV_W'(prod[2*PT_W-1:0]);
        div_b = DIV_W'(rdiff);
      end
    endcase
  end

  assign div_start = cmd.div_start;

  always_comb begin
    case (cmd.mul_sel)
      tmw_pkg::MUL_WARP: begin
        mul_a = span_r;
        mul_b = mapped_r;
      end
      default: begin
        mul_a = DIV_W'(vdiff);
        mul_b = wdiff;
      end
    endcase
  end

  assign warp_sum = {1'b0, base_r} + {1'b0, prod[tmw_pkg::FRAC_BITS +: DIV_W]};

  tmw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot),
    .rem_mid  (rem_mid)
  );

  tmw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      skew_r     <= '0;
      map_len_r  <= '0;
      beat_den_r <= tmw_pkg::DEN_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tmw_pkg::CFG_MAP_LENGTH: map_len_r  <= cfg_data;
          tmw_pkg::CFG_BEAT_DEN:   beat_den_r <= cfg_data[tmw_pkg::DEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        cnt_r  <= '0;
        skew_r <= '0;
      end else if (ins_en) begin
        cnt_r  <= cnt_r + 1'b1;
        skew_r <= skew_r + CNT_W'(skew_in_r);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      cx_r      <= tmw_pkg::clamp_unit(in_point_x);
      cy_r      <= tmw_pkg::clamp_unit(in_point_y);
      skew_in_r <= (in_point_x != in_point_y);
      v_r       <= tmw_pkg::clamp_unit(in_phase);
      tempo_r   <= in_tempo;
      t_r       <= in_clock_time;
      by_y_r    <= (in_op != tmw_pkg::OP_TO_CLOCK);
      result_r  <= '0;
      status_r  <= 1'b0;
    end
    if (cmd.insert && full) begin
      status_r <= 1'b1;
    end
    if (cmd.span_prep) begin
      num_r <= NUM_W'(map_len_r) * NUM_W'(tmw_pkg::BEAT_SCALE);
      den_r <= NUM_W'(tempo_r) * NUM_W'(beat_den_r);
    end
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
    end
    if (div_done) begin
      case (dsel_r)
        tmw_pkg::DIV_SPAN: span_r <= quot;
        tmw_pkg::DIV_TIME: begin
          v_r    <= PT_W'(quot[tmw_pkg::FRAC_BITS-1:0]);
          base_r <= DIV_W'(t_r) - rem_mid;
        end
        default: ;
      endcase
    end
    if (cmd.walk_init) begin
      i_r  <= '0;
      my_r <= '0;
      ax_r <= '0;
      ay_r <= '0;
    end
    if (cmd.walk_step) begin
      if (adv) begin
        ax_r <= rd_x;
        ay_r <= ny;
        my_r <= ny;
        i_r  <= i_r + 1'b1;
      end else if (at_end) begin
        bx_r <= tmw_pkg::ONE_Q;
        by_r <= tmw_pkg::ONE_Q;
      end else begin
        bx_r <= rd_x;
        by_r <= ny;
      end
    end
    if (cmd.seg_take) begin
      mapped_r <= seg_val;
    end
    if (cmd.map_take) begin
      result_r <= tmw_pkg::TIME_W'(mapped_r);
    end
    if (cmd.pass_take) begin
      result_r <= t_r;
    end
    if (cmd.warp_take) begin
      if (warp_sum > (DIV_W + 1)'(tmw_pkg::TIME_MAX)) begin
        result_r <= tmw_pkg::TIME_MAX;
      end else begin
        result_r <= warp_sum[tmw_pkg::TIME_W-1:0];
      end
    end
    if (cmd.publish) begin
      out_val_r <= result_r;
      out_st_r  <= status_r;
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.walk_last = !adv;
    stat.seg_skip  = seg_skip;
    stat.warp_pass = (num_r == '0) || (den_r == '0) || (skew_r == '0) ||
                     t_r[tmw_pkg::TIME_W-1];
    stat.span_zero = (span_r == '0);
    stat.div_done  = div_done;
    stat.mul_done  = mul_done;
  end

  assign out_result_value = $signed(out_val_r);
  assign out_status       = out_st_r;

endmodule

### sv/tmw_ctrl.sv
// controller: sequences each operation through the datapath and holds the output valid
module tmw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tmw_pkg::stat_t stat,
  output tmw_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK_INIT,
    S_WALK,
    S_SEG,
    S_SEG_MUL,
    S_SEG_DIV,
    S_MAP_END,
    S_W_MUL,
    S_SPAN_PREP,
    S_SPAN_DIV,
    S_SPAN_WAIT,
    S_SPAN_TEST,
    S_T_WAIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op) inside
          tmw_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end
          tmw_pkg::OP_INSERT: begin
            cmd.insert = 1'b1;
            state_nxt  = S_DONE;
          end
          tmw_pkg::OP_TO_CLOCK, tmw_pkg::OP_TO_REAL: state_nxt = S_WALK_INIT;
          tmw_pkg::OP_WARP:                          state_nxt = S_SPAN_PREP;
          default:                                   state_nxt = S_DONE;
        endcase
      end
      S_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        if (stat.seg_skip) begin
          cmd.seg_take = 1'b1;
          state_nxt    = S_MAP_END;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = tmw_pkg::MUL_SEG;
          state_nxt     = S_SEG_MUL;
        end
      end
      S_SEG_MUL: begin
        if (stat.mul_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tmw_pkg::DIV_SEG;
          state_nxt     = S_SEG_DIV;
        end
      end
      S_SEG_DIV: begin
        if (stat.div_done) begin
          cmd.seg_take = 1'b1;
          state_nxt    = S_MAP_END;
        end
      end
      S_MAP_END: begin
        if (stat.op == tmw_pkg::OP_WARP) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = tmw_pkg::MUL_WARP;
          state_nxt     = S_W_MUL;
        end else begin
          cmd.map_take = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_W_MUL: begin
        if (stat.mul_done) begin
          cmd.warp_take = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_SPAN_PREP: begin
        cmd.span_prep = 1'b1;
        state_nxt     = S_SPAN_DIV;
      end
      S_SPAN_DIV: begin
        if (stat.warp_pass) begin
          cmd.pass_take = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tmw_pkg::DIV_SPAN;
          state_nxt     = S_SPAN_WAIT;
        end
      end
      S_SPAN_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_SPAN_TEST;
        end
      end
      S_SPAN_TEST: begin
        if (stat.span_zero) begin
          cmd.pass_take = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tmw_pkg::DIV_TIME;
          state_nxt     = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_WALK_INIT;
        end
      end
      S_DONE: begin
        // output slot free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### test/tb_top.sv
// self-checking testbench for the time map warp block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tmw_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam longint unsigned UNIT_Q = 64'd1 << FRAC_BITS;
  localparam longint unsigned SPAN_SAT = 64'd1 << 62;
  localparam longint unsigned RES_SAT = (64'd1 << 47) - 1;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] ph;
    logic [DATA_W-1:0]        tempo;
    logic signed [TIME_W-1:0] ct;
  } map_req_t;

  typedef struct {
    logic [TIME_W-1:0] value;
    logic              status;
  } map_res_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [OP_W-1:0] in_op;
  logic signed [DATA_W-1:0] in_point_x, in_point_y, in_phase;
  logic [DATA_W-1:0] in_tempo;
  logic signed [TIME_W-1:0] in_clock_time, out_result_value;
  logic out_status;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0] cfg_data;

  map_req_t pending_q[$];
  map_res_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor state
  longint unsigned pt_x[MAX_POINTS];
  longint unsigned pt_y[MAX_POINTS];
  int pt_count = 0;
  int skew_count = 0;
  longint unsigned cur_len = 0;
  longint unsigned cur_den = 4;

  time_map_warp u_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned unit_clamp(logic signed [DATA_W-1:0] s);
    if (s < 0) return 0;
    if (longint'(s) > longint'(UNIT_Q)) return UNIT_Q;
    return longint'(s);
  endfunction

  // floor(r * 2^16 / d) for r < d
  function automatic longint unsigned fdiv(longint unsigned r, longint unsigned d);
    longint unsigned q = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    return q;
  endfunction

  // polyline corner k, y carries the running maximum
  function automatic void corner(int k, output longint unsigned x, output longint unsigned y);
    longint unsigned my = 0;
    if (k == 0) begin
      x = 0;
      y = 0;
    end else if (k > pt_count) begin
      x = UNIT_Q;
      y = UNIT_Q;
    end else begin
      for (int j = 0; j < k; j++) if (pt_y[j] > my) my = pt_y[j];
      x = pt_x[k-1];
      y = my;
    end
  endfunction

  function automatic longint unsigned map_lookup(longint unsigned v, bit inverse);
    int i = 0;
    longint unsigned nx, ny, ax, ay, bx, bv, ra, rb, wa, wb;
    while (i + 2 < pt_count + 2) begin
      corner(i + 1, nx, ny);
      if (!(v > (inverse ? ny : nx))) break;
      i++;
    end
    corner(i, ax, ay);
    corner(i + 1, bx, bv);
    ra = inverse ? ay : ax;
    rb = inverse ? bv : bx;
    wa = inverse ? ax : ay;
    wb = inverse ? bx : bv;
    // zero-width span, or a value below the span, gives the near end
    if (rb <= ra || v < ra) return wa;
    if (wb >= wa) return wa + ((v - ra) * (wb - wa)) / (rb - ra);
    return wa - ((v - ra) * (wa - wb)) / (rb - ra);
  endfunction

  function automatic longint unsigned cycle_span(longint unsigned tempo);
    longint unsigned num = cur_len * 240;
    longint unsigned den = tempo * cur_den;
    longint unsigned q;
    if (num == 0 || den == 0) return 0;
    q = num / den;
    if (q > (SPAN_SAT >> FRAC_BITS)) return SPAN_SAT;
    return (q << FRAC_BITS) + fdiv(num % den, den);
  endfunction

  function automatic logic [TIME_W-1:0] warp_time(logic [DATA_W-1:0] tempo,
                                                  logic signed [TIME_W-1:0] ct);
    longint unsigned span, t, cyc, mp, res;
    span = cycle_span(tempo);
    if (span == 0 || skew_count == 0 || ct < 0) return ct;
    t = longint'(ct);
    cyc = t / span;
    mp = map_lookup(fdiv(t % span, span), 1'b1);
    res = cyc * span + mp * (span >> FRAC_BITS) + ((mp * (span & (UNIT_Q - 1))) >> FRAC_BITS);
    if (res > RES_SAT) res = RES_SAT;
    return res[TIME_W-1:0];
  endfunction

  function automatic map_res_t predict_map(map_req_t r);
    map_res_t o;
    longint unsigned cx, cy;
    int pos;
    o.value = '0;
    o.status = 1'b0;
    case (r.op)
      OP_CLEAR: begin
        pt_count = 0;
        skew_count = 0;
      end
      OP_INSERT: begin
        if (pt_count >= MAX_POINTS) begin
          o.status = 1'b1;
        end else begin
          cx = unit_clamp(r.px);
          cy = unit_clamp(r.py);
          pos = 0;
          while (pos < pt_count && pt_x[pos] <= cx) pos++;
          for (int k = pt_count; k > pos; k--) begin
            pt_x[k] = pt_x[k-1];
            pt_y[k] = pt_y[k-1];
          end
          pt_x[pos] = cx;
          pt_y[pos] = cy;
          pt_count++;
          if (r.px != r.py) skew_count++;
        end
      end
      OP_TO_CLOCK: o.value = TIME_W'(map_lookup(unit_clamp(r.ph), 1'b0));
      OP_TO_REAL:  o.value = TIME_W'(map_lookup(unit_clamp(r.ph), 1'b1));
      OP_WARP:     o.value = warp_time(r.tempo, r.ct);
      default: ;
    endcase
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    map_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r.op = in_op; r.px = in_point_x; r.py = in_point_y;
        r.ph = in_phase; r.tempo = in_tempo; r.ct = in_clock_time;
        expected_q = {expected_q, predict_map(r)};
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_q.pop_front();
          in_op <= r.op; in_point_x <= r.px; in_point_y <= r.py;
          in_phase <= r.ph; in_tempo <= r.tempo; in_clock_time <= r.ct;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    map_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected: value %h status %b",
                   $time, out_result_value, out_status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_result_value !== e.value) begin
            $display("%0t: result_value expected %h actual %h", $time, e.value,
                     out_result_value);
            errors++;
          end
          if (out_status !== e.status) begin
            $display("%0t: status expected %b actual %b", $time, e.status, out_status);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("time_map_warp verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAP_LENGTH) cur_len = d;
    else cur_den = d[DEN_W-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic add(input logic [OP_W-1:0] op, input logic [31:0] px, input logic [31:0] py,
                     input logic [31:0] ph, input logic [31:0] tempo, input logic [47:0] ct);
    map_req_t r;
    r.op = op; r.px = px; r.py = py; r.ph = ph; r.tempo = tempo; r.ct = ct;
    pending_q = {pending_q, r};
  endtask

  // mostly near the unit interval, sometimes anywhere
  function automatic logic [31:0] rnd_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($urandom_range(32'h0001_4000)) - 32'h0000_2000;
  endfunction

  task automatic add_random();
    int sel = $urandom_range(99);
    logic [31:0] x, tempo;
    logic [47:0] ct;
    x = rnd_coord();
    case ($urandom_range(3))
      0: tempo = $urandom;
      1: tempo = 0;
      default: tempo = 32'($urandom_range(300, 1)) << 16 | 32'($urandom_range(16'hffff));
    endcase
    case ($urandom_range(3))
      0: ct = 48'({$urandom, $urandom});
      1: ct = -48'($urandom_range(32'hffff, 1));
      default: ct = 48'($urandom_range(32'h00ff_ffff));
    endcase
    if (sel < 3) add(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, ct);
    else if (sel < 33) add(OP_INSERT, x, ($urandom_range(4) == 0) ? x : rnd_coord(),
                           $urandom, tempo, ct);
    else if (sel < 50) add(OP_TO_CLOCK, $urandom, $urandom, rnd_coord(), tempo, ct);
    else if (sel < 67) add(OP_TO_REAL, $urandom, $urandom, rnd_coord(), tempo, ct);
    else if (sel < 97) add(OP_WARP, $urandom, $urandom, rnd_coord(), tempo, ct);
    else add(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, tempo, ct);
  endtask

  initial begin
    int lens[4] = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h0003_0000, 32'h0000_8000};
    int dens[4] = '{255, 0, 1, 8};
    int idle_s[4] = '{0, 54, 0, 27};
    int stall_r[4] = '{0, 0, 54, 27};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0; in_point_x = '0; in_point_y = '0; in_phase = '0;
    in_tempo = '0; in_clock_time = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(CFG_MAP_LENGTH, 32'h0004_0000);
    cfg_write(CFG_BEAT_DEN, 8'd4);
    // directed: extremes, equal x points, neutral map, bad codes, full table
    add(OP_WARP, 0, 0, 0, 32'h0078_0000, 48'h5_0000);
    add(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
    add(OP_INSERT, 32'h0000_8000, 32'h0000_4000, 0, 0, 0);
    add(OP_INSERT, 32'h0000_8000, 32'h0001_2000, 0, 0, 0);
    add(OP_INSERT, 32'h0000_4000, 32'h0000_4000, 0, 0, 0);
    add(OP_TO_CLOCK, 0, 0, 32'h8000_0000, 0, 0);
    add(OP_TO_CLOCK, 0, 0, 32'h7FFF_FFFF, 0, 0);
    add(OP_TO_CLOCK, 0, 0, 32'h0000_8000, 0, 0);
    add(OP_TO_REAL, 0, 0, 32'h0000_8000, 0, 0);
    add(OP_TO_REAL, 0, 0, 32'h0001_0000, 0, 0);
    add(OP_WARP, 0, 0, 0, 32'h0078_0000, 48'h5_0000);
    add(OP_WARP, 0, 0, 0, 32'h0078_0000, 48'h8000_0000_0000);
    add(OP_WARP, 0, 0, 0, 32'h0000_0000, 48'h5_0000);
    add(OP_WARP, 0, 0, 0, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    for (int op = 5; op < 8; op++) add(3'(op), 32'hFFFF_FFFF, 0, 0, 0, 0);
    repeat (13) add(OP_INSERT, rnd_coord(), rnd_coord(), 0, 0, 0);
    add(OP_WARP, 0, 0, 0, 32'h0078_0000, 48'h7_0000);
    add(OP_CLEAR, 0, 0, 0, 0, 0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      cfg_write(CFG_MAP_LENGTH, lens[p]);
      cfg_write(CFG_BEAT_DEN, dens[p]);
      send_idle_pct = idle_s[p];
      recv_stall_pct = stall_r[p];
      // the sender holds off mid-phase until the block has drained
      repeat (80) add_random();
      wait_idle();
      repeat (80) add_random();
      wait_idle();
    end

    if (errors == 0) begin
      $display("time_map_warp verification clean");
    end else begin
      $display("time_map_warp verification failed");
    end
    $finish;
  end

endmodule

### time_map_warp.f
sv/tmw_pkg.sv
sv/tmw_div.sv
sv/tmw_mul.sv
sv/tmw_dp.sv
sv/tmw_ctrl.sv
sv/time_map_warp.sv
test/tb_top.sv
